// ----- rtl/acf_pkg.sv -----
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types and constants for the alert cooldown filter.
// ----------------------------------------------------------------------------
package acf_pkg;

  // table geometry and register reset
  localparam int unsigned NUM_SLOTS_DEF  = 8;
  localparam int unsigned SLOT_IDX_W     = 3;
  localparam logic [31:0] COOLDOWN_RESET = 32'd60000;

  // result action codes
  typedef enum logic [1:0] {
    ACT_SUPPRESS = 2'd0,
    ACT_REFRESH  = 2'd1,
    ACT_CLAIM    = 2'd2,
    ACT_EVICT    = 2'd3
  } action_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_WRITE
  } state_t;

  // request item
  typedef struct packed {
    logic [7:0]  category_code;
    logic [7:0]  status_code;
    logic [31:0] now_ms;
  } request_t;

  // result item
  typedef struct packed {
    logic                  allow;
    action_t               action;
    logic [SLOT_IDX_W-1:0] slot_index;
  } result_t;

  // one stored slot: key and last allowed time
  typedef struct packed {
    logic [7:0]  category;
    logic [7:0]  status;
    logic [31:0] last_sent;
  } slot_entry_t;

endpackage

// ----- rtl/acf_slot_mem.sv -----
// ----------------------------------------------------------------------------
// acf_slot_mem
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module acf_slot_mem #(
  parameter int unsigned DEPTH  = acf_pkg::NUM_SLOTS_DEF,
  parameter int unsigned ADDR_W = 3
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  acf_pkg::slot_entry_t wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output acf_pkg::slot_entry_t rdata
);

  acf_pkg::slot_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/acf_ctrl.sv -----
// ----------------------------------------------------------------------------
// acf_ctrl
// Slot walk sequencer: reads slots to a key match or the last slot, tracks
// the first free slot, then loads the result, writing back unless suppressed.
// ----------------------------------------------------------------------------
module acf_ctrl #(
  parameter int unsigned NUM_SLOTS = acf_pkg::NUM_SLOTS_DEF,
  parameter int unsigned ADDR_W    = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          cooldown_ms,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  acf_pkg::request_t    req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output acf_pkg::result_t     rsp,
  output logic                 mem_we,
  output logic [ADDR_W-1:0]    mem_waddr,
  output acf_pkg::slot_entry_t mem_wdata,
  output logic                 mem_re,
  output logic [ADDR_W-1:0]    mem_raddr,
  input  acf_pkg::slot_entry_t mem_rdata
);

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_SLOTS - 1);

  acf_pkg::state_t   state, state_next;
  acf_pkg::request_t cur;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] hit_idx;
  logic [ADDR_W-1:0] free_idx;
  logic              hit;
  logic              too_soon;
  logic              free_found;
  logic              res_free;
  logic              entry_match;
  logic [31:0]       age;
  logic [ADDR_W-1:0] target;
  acf_pkg::action_t  act;

  // key compare and age of the slot just read
  assign entry_match = slot_valid[idx] &&
                       (mem_rdata.category == cur.category_code) &&
                       (mem_rdata.status == cur.status_code);
  assign age      = cur.now_ms - mem_rdata.last_sent;
  assign res_free = !rsp_valid || !rsp_stall;

  // decision once the walk is done
  always_comb begin
    if (hit) begin
      target = hit_idx;
      act    = too_soon ? acf_pkg::ACT_SUPPRESS : acf_pkg::ACT_REFRESH;
    end else if (free_found) begin
      target = free_idx;
      act    = acf_pkg::ACT_CLAIM;
    end else begin
      target = '0;
      act    = acf_pkg::ACT_EVICT;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      acf_pkg::ST_IDLE: begin
        if (req_valid) state_next = acf_pkg::ST_READ;
      end
      acf_pkg::ST_READ: state_next = acf_pkg::ST_CHECK;
      acf_pkg::ST_CHECK: begin
        if (entry_match || idx == LAST_IDX) state_next = acf_pkg::ST_WRITE;
        else state_next = acf_pkg::ST_READ;
      end
      acf_pkg::ST_WRITE: begin
        if (res_free) state_next = acf_pkg::ST_IDLE;
      end
      default: state_next = acf_pkg::ST_IDLE;
    endcase
  end

  // state outputs: handshake and memory ports
  always_comb begin
    req_stall = 1'b1;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    case (state)
      acf_pkg::ST_IDLE:  req_stall = 1'b0;
      acf_pkg::ST_READ:  mem_re = 1'b1;
      acf_pkg::ST_CHECK: mem_re = 1'b0;
      acf_pkg::ST_WRITE: mem_we = res_free && (act != acf_pkg::ACT_SUPPRESS);
      default:           req_stall = 1'b1;
    endcase
  end

  assign mem_raddr           = idx;
  assign mem_waddr           = target;
  assign mem_wdata.category  = cur.category_code;
  assign mem_wdata.status    = cur.status_code;
  assign mem_wdata.last_sent = cur.now_ms;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= acf_pkg::ST_IDLE;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == acf_pkg::ST_WRITE && res_free) begin
        rsp_valid <= 1'b1;
        if (act != acf_pkg::ACT_SUPPRESS) slot_valid[target] <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // walk registers and captured item
  always_ff @(posedge clk) begin
    case (state)
      acf_pkg::ST_IDLE: begin
        if (req_valid) begin
          cur        <= req;
          idx        <= '0;
          hit        <= 1'b0;
          free_found <= 1'b0;
        end
      end
      acf_pkg::ST_CHECK: begin
        if (entry_match) begin
          hit      <= 1'b1;
          hit_idx  <= idx;
          too_soon <= age < cooldown_ms;
        end else begin
          if (!slot_valid[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx != LAST_IDX) idx <= idx + 1'b1;
        end
      end
      acf_pkg::ST_WRITE: begin
        if (res_free) begin
          rsp.allow      <= (act != acf_pkg::ACT_SUPPRESS);
          rsp.action     <= act;
          rsp.slot_index <= acf_pkg::SLOT_IDX_W'(target);
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/alert_cooldown_filter_unit.sv -----
// ----------------------------------------------------------------------------
// alert_cooldown_filter_unit
// Per-key cooldown filter for alert requests over a small slot table.
// ----------------------------------------------------------------------------
// The sequencer takes one request item (category, status, time) at a time:
// it reads the slots in order through the slot memory's single read port,
// stops at the first key match or after the last slot, then writes back
// (unless the item is suppressed) and loads the result register. A result
// waiting on a stalled output does not block the next request until that
// request's own result is ready.
// The register cooldown_ms is written through the cfg channel, which is
// always ready; write it only while no request is in flight. No clearing
// pass is needed after reset: slot valid bits are flip-flops.
module alert_cooldown_filter_unit #(
  parameter int unsigned NUM_SLOTS = acf_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  acf_pkg::request_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output acf_pkg::result_t  rsp
);

  localparam int unsigned ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [31:0]          cooldown_ms;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  acf_pkg::slot_entry_t mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  acf_pkg::slot_entry_t mem_rdata;

  // cooldown register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_ms <= acf_pkg::COOLDOWN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cooldown_ms <= cfg_data;
    end
  end

  // slot walk sequencer
  acf_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cooldown_ms (cooldown_ms),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // slot table
  acf_slot_mem #(
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/acf_checker.sv -----
// ----------------------------------------------------------------------------
// acf_checker
// Port-level checks for the alert cooldown filter, bound to the top level.
// ----------------------------------------------------------------------------
module acf_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input acf_pkg::result_t  rsp
);

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // allow follows the action code
  a_allow_action: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.allow == (rsp.action != acf_pkg::ACT_SUPPRESS)))
    else $error("allow disagrees with action");

  // eviction always lands in slot zero
  a_evict_slot0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action == acf_pkg::ACT_EVICT |-> rsp.slot_index == '0)
    else $error("eviction reported outside slot zero");

  // one item in flight: an accepted item stalls the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous item in flight");

endmodule

bind alert_cooldown_filter_unit acf_checker u_acf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
